FILE: src/skl_pkg.sv
// Shared types and constants for the sorted key list engine.
// No dependencies; imported by the controller, the cell datapath and the top level.
package skl_pkg;

   localparam int KEY_W        = 13;
   localparam int FUNC_W       = 3;
   localparam int COUNT_OUT_W  = 7;
   localparam int CAPACITY_DEF = 64;

   localparam logic [FUNC_W-1:0] FN_LOOKUP    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd2;
   localparam logic [FUNC_W-1:0] FN_STEP_UP   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_STEP_DOWN = 3'd4;
   localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

   typedef struct packed {
      logic capture;
      logic insert;
      logic remove;
      logic clear;
      logic step_up;
      logic step_down;
      logic load;
      logic ok;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic full;
      logic empty;
   } sts_type;

endpackage

FILE: src/skl_cells.sv
// Cell row datapath: sorted key storage, per-cell compare flags, shift network,
// neighbor selection, entry count and response payload registers. Uses skl_pkg.
module skl_cells import skl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [KEY_W-1:0]       req_key,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic                   rsp_ok,
   output logic [KEY_W-1:0]       rsp_key_out,
   output logic [COUNT_OUT_W-1:0] rsp_count_out
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [KEY_W-1:0]       entry_ff [CAPACITY];
   logic [KEY_W-1:0]       entry_in [CAPACITY];
   logic [KEY_W-1:0]       ins_val  [CAPACITY];
   logic [KEY_W-1:0]       rem_val  [CAPACITY];
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [KEY_W-1:0]       key_ff;
   logic [CAPACITY-1:0]    valid;
   logic [CAPACITY-1:0]    lt_now;
   logic [CAPACITY-1:0]    le_now;
   logic [CAPACITY-1:0]    eq_now;
   logic [CAPACITY-1:0]    lt_ff;
   logic [CAPACITY-1:0]    le_ff;
   logic                   found_ff;
   logic [CAPACITY-1:0]    up_oh;
   logic [CAPACITY-1:0]    last_lt;
   logic [CAPACITY-1:0]    last_v;
   logic [KEY_W-1:0]       up_sel;
   logic [KEY_W-1:0]       lt_sel;
   logic [KEY_W-1:0]       v_sel;
   logic [KEY_W-1:0]       key_sel;
   logic                   rsp_ok_ff;
   logic [KEY_W-1:0]       rsp_key_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign valid[g]  = (CNT_W'(g) < count_ff);
      assign lt_now[g] = valid[g] && (entry_ff[g] <  req_key);
      assign le_now[g] = valid[g] && (entry_ff[g] <= req_key);
      assign eq_now[g] = valid[g] && (entry_ff[g] == req_key);

      if (g == 0) begin : g_first
         assign ins_val[g] = lt_ff[g] ? entry_ff[g] : key_ff;
         assign up_oh[g]   = valid[g] && !le_ff[g];
      end else begin : g_rest
         assign ins_val[g] = lt_ff[g] ? entry_ff[g] : (lt_ff[g-1] ? key_ff : entry_ff[g-1]);
         assign up_oh[g]   = valid[g] && !le_ff[g] && le_ff[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign rem_val[g] = entry_ff[g];
         assign last_lt[g] = lt_ff[g];
         assign last_v[g]  = valid[g];
      end else begin : g_mid
         assign rem_val[g] = lt_ff[g] ? entry_ff[g] : entry_ff[g+1];
         assign last_lt[g] = lt_ff[g] && !lt_ff[g+1];
         assign last_v[g]  = valid[g] && !valid[g+1];
      end

      assign entry_in[g] = cmd.insert ? ins_val[g] : rem_val[g];
   end

   always_comb begin
      up_sel = '0;
      lt_sel = '0;
      v_sel  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         up_sel = up_sel | ({KEY_W{up_oh[i]}}   & entry_ff[i]);
         lt_sel = lt_sel | ({KEY_W{last_lt[i]}} & entry_ff[i]);
         v_sel  = v_sel  | ({KEY_W{last_v[i]}}  & entry_ff[i]);
      end
   end

   always_comb begin
      if (cmd.step_up) begin
         key_sel = (|up_oh) ? up_sel : entry_ff[0];
      end else if (cmd.step_down) begin
         key_sel = lt_ff[0] ? lt_sel : v_sel;
      end else begin
         key_sel = '0;
      end
   end

   always_comb begin
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lt_ff    <= lt_now;
         le_ff    <= le_now;
         found_ff <= |eq_now;
         key_ff   <= req_key;
      end
      if (cmd.insert || cmd.remove) begin
         for (int i = 0; i < CAPACITY; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
      if (cmd.load) begin
         rsp_ok_ff    <= cmd.ok;
         rsp_key_ff   <= key_sel;
         rsp_count_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign sts.found = found_ff;
   assign sts.full  = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty = (count_ff == '0);

   assign rsp_ok        = rsp_ok_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_count_out = rsp_count_ff;

endmodule

FILE: src/skl_ctrl.sv
// Request sequencer: accepts a beat, decodes the operation against the cell
// status and issues commands to skl_cells; owns the response valid. Uses skl_pkg.
module skl_ctrl import skl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FUNC_W-1:0] req_func,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  sts_type           sts,
   output cmd_type           cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff;
   logic              state_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [FUNC_W-1:0] func_ff;
   logic              accept;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         state_in = ST_EXEC;
      end
      if ((state_ff == ST_EXEC) && out_free) begin
         cmd.load     = 1'b1;
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         case (func_ff)
            FN_LOOKUP: begin
               cmd.ok = sts.found;
            end
            FN_INSERT: begin
               cmd.ok     = !sts.full && !sts.found;
               cmd.insert = !sts.full && !sts.found;
            end
            FN_REMOVE: begin
               cmd.ok     = sts.found;
               cmd.remove = sts.found;
            end
            FN_STEP_UP: begin
               cmd.ok      = !sts.empty;
               cmd.step_up = !sts.empty;
            end
            FN_STEP_DOWN: begin
               cmd.ok        = !sts.empty;
               cmd.step_down = !sts.empty;
            end
            FN_CLEAR: begin
               cmd.ok    = 1'b1;
               cmd.clear = 1'b1;
            end
            default: begin
               cmd.ok = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/sorted_key_list_engine.sv
// Sorted key list engine: keeps up to CAPACITY distinct 13-bit keys in ascending
// order and serves lookup, insert, remove, step up, step down and clear requests.
// When a request is accepted every cell compares its key with the request key and
// the flags are registered; in the execute state, once the output is free, the row
// shifts in parallel, the neighbor is selected and the response register loads.
// No new request is accepted until then, and the execute state is held only while
// a loaded response is held by rsp_stall.
// Depends on skl_pkg, skl_ctrl and skl_cells.
module sorted_key_list_engine import skl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [KEY_W-1:0]       req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_ok,
   output logic [KEY_W-1:0]       rsp_key_out,
   output logic [COUNT_OUT_W-1:0] rsp_count_out
);

   cmd_type cmd;
   sts_type sts;

   skl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   skl_cells #(
      .CAPACITY (CAPACITY)
   ) u_cells (
      .clock         (clock),
      .reset         (reset),
      .req_key       (req_key),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ok        (rsp_ok),
      .rsp_key_out   (rsp_key_out),
      .rsp_count_out (rsp_count_out)
   );

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CAPACITY > 127) || (rsp_count_out <= CAPACITY)))
      else $error("response count above capacity");

   a_fail_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_key_out == '0))
      else $error("failed request returned a nonzero key");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(rsp_valid && rsp_stall)) |=> ##1 rsp_valid)
      else $error("response missing after accepted request");
`endif

endmodule
